>>> sv/ogru_pkg.sv
// Package for the occupancy grid ray update block.
// Holds the default parameters, mode and register codes, and the sequencer state type.
// No dependencies.
`default_nettype none
package ogru_pkg;
  localparam int GRID_WIDTH_DEF     = 256;
  localparam int GRID_HEIGHT_DEF    = 256;
  localparam int CONF_FRAC_BITS_DEF = 8;
  localparam int TIME_BITS_DEF      = 32;

  localparam logic [7:0]  MIN_DET_RST    = 8'd2;
  localparam logic [31:0] DECAY_TIME_RST = 32'd300;
  localparam logic [31:0] MAX_AGE_RST    = 32'd3000;

  localparam logic [6:0]  OCC_VALUE = 7'd100;
  localparam logic [15:0] CONF_MAX  = 16'hFFFF;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    MODE_MARK  = 2'd0,
    MODE_RAY   = 2'd1,
    MODE_SWEEP = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MIN_DET    = 3'd0,
    REG_DECAY_TIME = 3'd1,
    REG_MAX_AGE    = 3'd2,
    REG_SWEEP_EN   = 3'd3,
    REG_GRID_COLS  = 3'd4,
    REG_GRID_ROWS  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MK_RD,
    S_MK_WR,
    S_RAY_STEP,
    S_RAY_CHK,
    S_SW_RD,
    S_SW_EVAL,
    S_SW_DIV,
    S_SW_MUL,
    S_FIN_RD,
    S_FIN_OUT
  } state_t;
endpackage
`default_nettype wire

>>> sv/ogru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ogru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> sv/occupancy_grid_ray_update.sv
// Top level of the occupancy grid ray update block: sequencer, Bresenham walker,
// sweep ager with a radix-2 divider, and one cell RAM (ogru_ram). Uses ogru_pkg.
`default_nettype none
// Usage:
//   Command channel: present in_* fields and raise start while busy is low; the beat
//   is taken at that edge and busy stays high until the result has been shown.
//   Result channel: out_valid is high for exactly one cycle with the cell fields and
//   cells_cleared; the receiver cannot stall, so the result must be taken then.
//   Config channel: cfg_ready is always high; a beat (cfg_valid) writes register
//   cfg_index with cfg_data. Unknown indexes are dropped. Write only while idle.
// Steps per command, from the accepting edge to the result, set by the single RAM
// port pair that every step goes through:
//   read: target read and shown; mark: target read and written back, then shown
//   (no write for a target off the grid); ray: walks each cell, and each cell inside
//   the grid is also read and checked; sweep: each cell read and evaluated, a decaying
//   cell also passing the one-bit-per-cycle divider and a multiply step. A disabled
//   sweep goes straight to the result. busy drops in the cycle after the result.
// Reset: rst_n clears the control and config registers to their defaults, then a
//   clearing pass writes zero to every cell (GRID_WIDTH * GRID_HEIGHT, 65536 at the
//   defaults), with busy high. Config beats are taken during that pass.
module occupancy_grid_ray_update
  import ogru_pkg::*;
#(
  parameter int GRID_WIDTH     = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT    = GRID_HEIGHT_DEF,
  parameter int CONF_FRAC_BITS = CONF_FRAC_BITS_DEF,
  parameter int TIME_BITS      = TIME_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [10:0] in_start_x,
  input  wire logic signed [10:0] in_start_y,
  input  wire logic signed [10:0] in_end_x,
  input  wire logic signed [10:0] in_end_y,
  input  wire logic [31:0]        in_now_time,
  output logic                    out_valid,
  output logic [6:0]              out_occupancy,
  output logic [15:0]             out_confidence,
  output logic [31:0]             out_seen_time,
  output logic                    out_in_grid,
  output logic [16:0]             out_cells_cleared,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XB    = $clog2(GRID_WIDTH);
  localparam int YB    = $clog2(GRID_HEIGHT);
  localparam int CXW   = $clog2(GRID_WIDTH + 1);
  localparam int CYW   = $clog2(GRID_HEIGHT + 1);
  localparam int TW    = TIME_BITS;
  localparam int CW    = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int WW    = 17 + TIME_BITS;
  localparam int THW   = 8 + CONF_FRAC_BITS;
  localparam logic [16:0] CONF_ONE = 17'(1) << CONF_FRAC_BITS;

  function automatic logic [AW-1:0] cell_addr(input logic [YB-1:0] y, input logic [XB-1:0] x);
    return AW'(32'(y) * 32'(GRID_WIDTH) + 32'(x));
  endfunction

  // Config registers
  logic [7:0]     min_det_r;
  logic [31:0]    decay_r, max_age_r;
  logic           sweep_en_r;
  logic [CXW-1:0] cols_r;
  logic [CYW-1:0] rows_r;

  // Sequencer and command registers
  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic signed [10:0] end_x_r, end_y_r, end_x_nxt, end_y_nxt;
  logic [TW-1:0]  now_r, now_nxt;
  logic [16:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;

  // Bresenham walker
  logic signed [13:0] rx_r, ry_r, dx_r, dy_r, err_r;
  logic signed [13:0] rx_nxt, ry_nxt, dx_nxt, dy_nxt, err_nxt;
  logic stx_r, sty_r, stx_nxt, sty_nxt;

  // Sweep walker and divider
  logic [CXW-1:0] swx_r, swx_nxt;
  logic [CYW-1:0] swy_r, swy_nxt;
  logic [AW-1:0]  rbase_r, rbase_nxt;
  logic [31:0]    rem_r, rem_nxt, den_r, den_nxt;
  logic [15:0]    q_r, q_nxt, conf_r, conf_nxt;
  logic [3:0]     dcnt_r, dcnt_nxt;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;
  logic          rd_occ;
  logic [15:0]   rd_conf;
  logic [TW-1:0] rd_last;

  assign rd_occ  = ram_rdata[WW-1];
  assign rd_conf = ram_rdata[WW-2 -: 16];
  assign rd_last = ram_rdata[TW-1:0];

  ogru_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Target cell of the command; a sweep never reports a cell
  logic          end_in, tin_eff;
  logic [AW-1:0] end_addr;
  assign end_in = !end_x_r[10] && !end_y_r[10] &&
                  (32'(end_x_r[9:0]) < 32'(cols_r)) && (32'(end_y_r[9:0]) < 32'(rows_r));
  assign tin_eff  = end_in && (mode_r != MODE_SWEEP);
  assign end_addr = cell_addr(YB'(end_y_r[9:0]), XB'(end_x_r[9:0]));

  // Ray walker helpers
  logic          ray_in, ray_done, c_x, c_y;
  logic [AW-1:0] ray_addr;
  logic signed [13:0] e2;
  assign ray_in = !rx_r[13] && !ry_r[13] &&
                  (32'(rx_r[12:0]) < 32'(cols_r)) && (32'(ry_r[12:0]) < 32'(rows_r));
  assign ray_addr = cell_addr(YB'(ry_r[12:0]), XB'(rx_r[12:0]));
  assign ray_done = (rx_r == 14'(end_x_r)) && (ry_r == 14'(end_y_r));
  assign e2  = err_r <<< 1;
  assign c_x = e2 > -dy_r;
  assign c_y = e2 < dx_r;

  // Sweep helpers
  logic [AW-1:0] sw_addr;
  logic          sw_last_col, sw_last_row;
  logic [TW-1:0] age;
  logic [CW-1:0] age_ext, max_ext, decay_ext;
  logic [THW-1:0] thr;
  logic [32:0]   rem_sh;
  logic [31:0]   prod;
  assign sw_addr     = rbase_r + AW'(swx_r);
  assign sw_last_col = (swx_r + CXW'(1)) >= cols_r;
  assign sw_last_row = (swy_r + CYW'(1)) >= rows_r;
  assign age       = (now_r >= rd_last) ? (now_r - rd_last) : '0;
  assign age_ext   = CW'(age);
  assign max_ext   = CW'(max_age_r);
  assign decay_ext = CW'(decay_r);
  assign thr       = THW'(min_det_r) << CONF_FRAC_BITS;
  assign rem_sh    = {rem_r, 1'b0};
  assign prod      = 32'(conf_r) * 32'(q_r);

  // Mark arithmetic
  logic [16:0] mk_sum;
  logic [15:0] mk_conf;
  assign mk_sum  = 17'(rd_conf) + CONF_ONE;
  assign mk_conf = (mk_sum > 17'(CONF_MAX)) ? CONF_MAX : mk_sum[15:0];

  logic [16:0] cnt_bump;
  assign cnt_bump = (cnt_r == COUNT_MAX) ? COUNT_MAX : cnt_r + 17'd1;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (mode_t'(in_mode))
            MODE_MARK:  state_nxt = S_MK_RD;
            MODE_RAY:   state_nxt = S_RAY_STEP;
            MODE_SWEEP: state_nxt = sweep_en_r ? S_SW_RD : S_FIN_RD;
            MODE_READ:  state_nxt = S_FIN_RD;
          endcase
        end
      end
      S_MK_RD:    state_nxt = end_in ? S_MK_WR : S_FIN_RD;
      S_MK_WR:    state_nxt = S_FIN_RD;
      S_RAY_STEP: begin
        if (ray_done) state_nxt = S_FIN_RD;
        else if (ray_in) state_nxt = S_RAY_CHK;
      end
      S_RAY_CHK:  state_nxt = S_RAY_STEP;
      S_SW_RD:    state_nxt = S_SW_EVAL;
      S_SW_EVAL: begin
        if (rd_occ && age_ext <= max_ext && age_ext > decay_ext) state_nxt = S_SW_DIV;
        else if (sw_last_col && sw_last_row) state_nxt = S_FIN_RD;
        else state_nxt = S_SW_RD;
      end
      S_SW_DIV:   if (dcnt_r == 4'd15) state_nxt = S_SW_MUL;
      S_SW_MUL:   state_nxt = (sw_last_col && sw_last_row) ? S_FIN_RD : S_SW_RD;
      S_FIN_RD:   state_nxt = S_FIN_OUT;
      S_FIN_OUT:  state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    mode_nxt = mode_r;   end_x_nxt = end_x_r; end_y_nxt = end_y_r;
    now_nxt  = now_r;    cnt_nxt   = cnt_r;   clr_nxt   = clr_r;
    rx_nxt   = rx_r;     ry_nxt    = ry_r;    dx_nxt    = dx_r;
    dy_nxt   = dy_r;     err_nxt   = err_r;   stx_nxt   = stx_r;  sty_nxt = sty_r;
    swx_nxt  = swx_r;    swy_nxt   = swy_r;   rbase_nxt = rbase_r;
    rem_nxt  = rem_r;    den_nxt   = den_r;   q_nxt     = q_r;
    conf_nxt = conf_r;   dcnt_nxt  = dcnt_r;
    ram_we = 1'b0; ram_re = 1'b0; ram_waddr = '0; ram_raddr = '0; ram_wdata = '0;
    out_valid = 1'b0; out_occupancy = '0; out_confidence = '0; out_seen_time = '0;
    out_in_grid = 1'b0; out_cells_cleared = cnt_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
      end
      S_IDLE: begin
        mode_nxt  = mode_t'(in_mode);
        end_x_nxt = in_end_x;
        end_y_nxt = in_end_y;
        now_nxt   = TW'(in_now_time);
        cnt_nxt   = '0;
        rx_nxt    = 14'(in_start_x);
        ry_nxt    = 14'(in_start_y);
        dx_nxt    = (in_end_x > in_start_x) ? 14'(in_end_x) - 14'(in_start_x)
                                            : 14'(in_start_x) - 14'(in_end_x);
        dy_nxt    = (in_end_y > in_start_y) ? 14'(in_end_y) - 14'(in_start_y)
                                            : 14'(in_start_y) - 14'(in_end_y);
        err_nxt   = dx_nxt - dy_nxt;
        stx_nxt   = in_start_x < in_end_x;
        sty_nxt   = in_start_y < in_end_y;
        swx_nxt   = '0;
        swy_nxt   = '0;
        rbase_nxt = '0;
      end
      S_MK_RD: begin
        ram_re    = end_in;
        ram_raddr = end_addr;
      end
      S_MK_WR: begin
        ram_we    = 1'b1;
        ram_waddr = end_addr;
        ram_wdata = {rd_occ || (THW'(mk_conf) >= thr), mk_conf, now_r};
      end
      S_RAY_STEP: begin
        if (!ray_done) begin
          if (ray_in) begin
            ram_re    = 1'b1;
            ram_raddr = ray_addr;
          end else begin
            err_nxt = err_r - (c_x ? dy_r : 14'sd0) + (c_y ? dx_r : 14'sd0);
            if (c_x) rx_nxt = stx_r ? rx_r + 14'sd1 : rx_r - 14'sd1;
            if (c_y) ry_nxt = sty_r ? ry_r + 14'sd1 : ry_r - 14'sd1;
          end
        end
      end
      S_RAY_CHK: begin
        // Drop the hit but keep its time stamp
        if (rd_occ) begin
          ram_we    = 1'b1;
          ram_waddr = ray_addr;
          ram_wdata = {1'b0, 16'd0, rd_last};
          cnt_nxt   = cnt_bump;
        end
        err_nxt = err_r - (c_x ? dy_r : 14'sd0) + (c_y ? dx_r : 14'sd0);
        if (c_x) rx_nxt = stx_r ? rx_r + 14'sd1 : rx_r - 14'sd1;
        if (c_y) ry_nxt = sty_r ? ry_r + 14'sd1 : ry_r - 14'sd1;
      end
      S_SW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sw_addr;
      end
      S_SW_EVAL, S_SW_MUL: begin
        if (state_r == S_SW_EVAL) begin
          if (rd_occ && age_ext > max_ext) begin
            ram_we    = 1'b1;
            ram_waddr = sw_addr;
            ram_wdata = '0;
            cnt_nxt   = cnt_bump;
          end else if (rd_occ && age_ext > decay_ext) begin
            // Start the decay factor division; remainder starts below the divisor
            rem_nxt  = max_age_r - 32'(age);
            den_nxt  = max_age_r - decay_r;
            q_nxt    = '0;
            dcnt_nxt = '0;
            conf_nxt = rd_conf;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = sw_addr;
          if (THW'(prod[31:16]) < thr) begin
            ram_wdata = {1'b0, 16'd0, rd_last};
            cnt_nxt   = cnt_bump;
          end else begin
            ram_wdata = {1'b1, prod[31:16], rd_last};
          end
        end
        // Advance to the next cell unless the divider takes over
        if (state_r == S_SW_MUL || state_nxt != S_SW_DIV) begin
          if (!sw_last_col) begin
            swx_nxt = swx_r + CXW'(1);
          end else begin
            swx_nxt   = '0;
            swy_nxt   = swy_r + CYW'(1);
            rbase_nxt = rbase_r + AW'(GRID_WIDTH);
          end
        end
      end
      S_SW_DIV: begin
        if (rem_sh >= 33'(den_r)) begin
          rem_nxt = 32'(rem_sh - 33'(den_r));
          q_nxt   = {q_r[14:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[31:0];
          q_nxt   = {q_r[14:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 4'd1;
      end
      S_FIN_RD: begin
        ram_re    = tin_eff;
        ram_raddr = end_addr;
      end
      S_FIN_OUT: begin
        out_valid = 1'b1;
        if (tin_eff) begin
          out_occupancy  = rd_occ ? OCC_VALUE : 7'd0;
          out_confidence = rd_conf;
          out_seen_time  = 32'(rd_last);
          out_in_grid    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      mode_r  <= MODE_MARK;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      mode_r  <= mode_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    end_x_r <= end_x_nxt; end_y_r <= end_y_nxt; now_r <= now_nxt;
    rx_r <= rx_nxt; ry_r <= ry_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt; err_r <= err_nxt;
    stx_r <= stx_nxt; sty_r <= sty_nxt;
    swx_r <= swx_nxt; swy_r <= swy_nxt; rbase_r <= rbase_nxt;
    rem_r <= rem_nxt; den_r <= den_nxt; q_r <= q_nxt; conf_r <= conf_nxt;
  end

  // Config registers; grid sizes clamp to 1..GRID_WIDTH and 1..GRID_HEIGHT
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_det_r  <= MIN_DET_RST;
      decay_r    <= DECAY_TIME_RST;
      max_age_r  <= MAX_AGE_RST;
      sweep_en_r <= 1'b1;
      cols_r     <= (256 > GRID_WIDTH) ? CXW'(GRID_WIDTH) : CXW'(256);
      rows_r     <= (256 > GRID_HEIGHT) ? CYW'(GRID_HEIGHT) : CYW'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_DET:    min_det_r  <= cfg_data[7:0];
        REG_DECAY_TIME: decay_r    <= cfg_data;
        REG_MAX_AGE:    max_age_r  <= cfg_data;
        REG_SWEEP_EN:   sweep_en_r <= cfg_data[0];
        REG_GRID_COLS: begin
          if (cfg_data[8:0] == 9'd0) cols_r <= CXW'(1);
          else if (32'(cfg_data[8:0]) > 32'(GRID_WIDTH)) cols_r <= CXW'(GRID_WIDTH);
          else cols_r <= CXW'(cfg_data[8:0]);
        end
        REG_GRID_ROWS: begin
          if (cfg_data[8:0] == 9'd0) rows_r <= CYW'(1);
          else if (32'(cfg_data[8:0]) > 32'(GRID_HEIGHT)) rows_r <= CYW'(GRID_HEIGHT);
          else rows_r <= CYW'(cfg_data[8:0]);
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/ogru_checker.sv
// Port-level checker for occupancy_grid_ray_update, attached by bind.
// Depends only on the top level's ports.
`default_nettype none
module ogru_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [6:0]  out_occupancy,
  input wire logic [15:0] out_confidence,
  input wire logic [31:0] out_seen_time,
  input wire logic        out_in_grid
);
  // A result strobe lasts one cycle
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // An accepted command makes the block busy
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("command beat did not raise busy");

  // A result only comes while a command is in flight, and it closes it
  a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 !busy) else $error("result outside a command");

  // Outside the grid every cell field reads as zero
  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_grid |->
      out_occupancy == 7'd0 && out_confidence == 16'd0 && out_seen_time == 32'd0)
    else $error("cell fields set for a target outside the grid");

  // Occupancy is free or occupied only
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy == 7'd0 || out_occupancy == 7'd100)
    else $error("occupancy not 0 or 100");
endmodule

bind occupancy_grid_ray_update ogru_checker u_ogru_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_occupancy  (out_occupancy),
  .out_confidence (out_confidence),
  .out_seen_time  (out_seen_time),
  .out_in_grid    (out_in_grid)
);
`default_nettype wire

>>> tb/occupancy_grid_ray_update_tb.sv
// Self-checking testbench for occupancy_grid_ray_update: directed table, then random phases
// under several register settings, every result checked against a grid model or typed row.
// Depends on ogru_pkg and the occupancy_grid_ray_update RTL.
`default_nettype none
module occupancy_grid_ray_update_tb;
  import ogru_pkg::*;

  localparam int GW = 256;
  localparam int GH = 256;
  localparam int RANDOM_ITEMS = 368;
  // indexes that decode to no register
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [6:0]  occ;
    logic [15:0] conf;
    logic [31:0] seen;
    logic        ing;
    logic [16:0] cleared;
  } cell_result_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [10:0] sx;
    logic signed [10:0] sy;
    logic signed [10:0] ex;
    logic signed [10:0] ey;
    logic [31:0]        now;
    logic               typed;
    cell_result_t       res;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = '0;
  logic signed [10:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic [31:0] in_now_time = '0;
  logic out_valid;
  logic [6:0] out_occupancy;
  logic [15:0] out_confidence;
  logic [31:0] out_seen_time;
  logic out_in_grid;
  logic [16:0] out_cells_cleared;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  occupancy_grid_ray_update uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_now_time(in_now_time),
    .out_valid(out_valid), .out_occupancy(out_occupancy), .out_confidence(out_confidence),
    .out_seen_time(out_seen_time), .out_in_grid(out_in_grid),
    .out_cells_cleared(out_cells_cleared),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow grid and register copies
  bit          occ_map [GW*GH];
  logic [15:0] conf_map [GW*GH];
  logic [31:0] seen_map [GW*GH];
  logic [7:0]  min_det;
  logic [31:0] decay_t;
  logic [31:0] max_age_r;
  logic        sweep_en;
  int unsigned cols;
  int unsigned rows;

  cell_result_t pending_q[$];
  int errors = 0;
  int sent = 0;
  bit quiet = 1'b0;
  logic [31:0] clock_ticks = 0;

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Compare each result beat with the oldest pending expectation.
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", out_cells_cleared, 0);
      end else begin
        want = pending_q.pop_front();
        if (out_occupancy !== want.occ) report("occupancy", out_occupancy, want.occ);
        if (out_confidence !== want.conf) report("confidence", out_confidence, want.conf);
        if (out_seen_time !== want.seen) report("seen_time", out_seen_time, want.seen);
        if (out_in_grid !== want.ing) report("in_grid", out_in_grid, want.ing);
        if (out_cells_cleared !== want.cleared)
          report("cells_cleared", out_cells_cleared, want.cleared);
      end
    end
  end

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < cols && y < rows;
  endfunction

  function automatic logic [16:0] count_up(logic [16:0] c);
    return (c == COUNT_MAX) ? c : c + 17'd1;
  endfunction

  function automatic int unsigned clamp_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  task automatic age_grid(logic [31:0] now, output logic [16:0] cnt);
    longint unsigned age, f, nc, thr;
    int i;
    cnt = '0;
    thr = longint'(min_det) << 8;
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        i = y * GW + x;
        if (occ_map[i]) begin
          age = (now >= seen_map[i]) ? now - seen_map[i] : 0;
          if (age > max_age_r) begin
            occ_map[i] = 0; conf_map[i] = '0; seen_map[i] = '0;
            cnt = count_up(cnt);
          end else if (age > decay_t) begin
            f = ((longint'(max_age_r) - age) << 16) / (longint'(max_age_r) - decay_t);
            nc = (longint'(conf_map[i]) * f) >> 16;
            if (nc < thr) begin
              occ_map[i] = 0; conf_map[i] = '0;
              cnt = count_up(cnt);
            end else begin
              conf_map[i] = nc[15:0];
            end
          end
        end
      end
    end
  endtask

  task automatic clear_along_ray(int x0, int y0, int x1, int y1, output logic [16:0] cnt);
    int dx, dy, stx, sty, err, e2, x, y;
    cnt = '0;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    stx = (x0 < x1) ? 1 : -1;
    sty = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    x = x0; y = y0;
    while (!(x == x1 && y == y1)) begin
      if (on_grid(x, y) && occ_map[y*GW + x]) begin
        occ_map[y*GW + x] = 0; conf_map[y*GW + x] = '0;
        cnt = count_up(cnt);
      end
      e2 = 2 * err;
      if (e2 > -dy) begin err -= dy; x += stx; end
      if (e2 < dx) begin err += dx; y += sty; end
    end
  endtask

  // Advance the shadow grid by one command and return the cell it reports.
  task automatic update_grid(cmd_row_t c, output cell_result_t r);
    int ex, ey, i;
    bit tin;
    logic [16:0] cleared;
    logic [16:0] sum;
    ex = c.ex; ey = c.ey;
    tin = on_grid(ex, ey);
    cleared = '0;
    case (c.mode)
      MODE_MARK: begin
        if (tin) begin
          i = ey * GW + ex;
          sum = conf_map[i] + 17'd256;
          if (sum > CONF_MAX) sum = CONF_MAX;
          conf_map[i] = sum[15:0];
          seen_map[i] = c.now;
          if (sum >= ({9'd0, min_det} << 8)) occ_map[i] = 1;
        end
      end
      MODE_RAY: clear_along_ray(c.sx, c.sy, ex, ey, cleared);
      MODE_SWEEP: begin
        if (sweep_en) age_grid(c.now, cleared);
        tin = 0;
      end
      default: ;
    endcase
    r = '0;
    if (tin) begin
      i = ey * GW + ex;
      r.occ = occ_map[i] ? OCC_VALUE : 7'd0;
      r.conf = conf_map[i];
      r.seen = seen_map[i];
      r.ing = 1'b1;
    end
    r.cleared = cleared;
  endtask

  // Issue one command beat; wait until busy is low, then raise start and queue its result.
  task automatic send_cmd(cmd_row_t c);
    cell_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 11)) @(negedge clk);
    @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1'b1;
    in_mode <= c.mode;
    in_start_x <= c.sx; in_start_y <= c.sy;
    in_end_x <= c.ex; in_end_y <= c.ey;
    in_now_time <= c.now;
    @(posedge clk);
    update_grid(c, r);
    pending_q.insert(pending_q.size(), c.typed ? c.res : r);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_DET:    min_det = data[7:0];
      REG_DECAY_TIME: decay_t = data;
      REG_MAX_AGE:    max_age_r = data;
      REG_SWEEP_EN:   sweep_en = data[0];
      REG_GRID_COLS:  cols = clamp_dim(data[8:0]);
      REG_GRID_ROWS:  rows = clamp_dim(data[8:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain all pending results and make sure the sequencer is idle.
  task automatic settle();
    @(negedge clk);
    while (pending_q.size() != 0 || busy) @(negedge clk);
  endtask

  // Junk in the upper bits checks that narrow registers mask their data.
  task automatic load_regs(logic [7:0] md, logic [31:0] dt, logic [31:0] ma, logic en,
                           logic [8:0] c, logic [8:0] r);
    write_reg(REG_MIN_DET, {$urandom} << 8 | md);
    write_reg(REG_DECAY_TIME, dt);
    write_reg(REG_MAX_AGE, ma);
    write_reg(REG_SWEEP_EN, {$urandom} << 1 | en);
    write_reg(REG_GRID_COLS, {$urandom} << 9 | c);
    write_reg(REG_GRID_ROWS, {$urandom} << 9 | r);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
  endtask

  function automatic logic signed [10:0] pick_coord(int unsigned dim);
    if ($urandom_range(0, 19) == 0) return 11'($urandom);
    return 11'($signed($urandom_range(0, dim + 3)) - 2);
  endfunction

  function automatic cmd_row_t random_cmd();
    cmd_row_t c;
    int unsigned p;
    c = '0;
    p = $urandom_range(0, 99);
    c.mode = (p < 40) ? MODE_MARK : (p < 65) ? MODE_RAY : (p < 85) ? MODE_READ : MODE_SWEEP;
    c.sx = pick_coord(cols); c.sy = pick_coord(rows);
    c.ex = pick_coord(cols); c.ey = pick_coord(rows);
    p = $urandom_range(0, 19);
    if (p == 0) clock_ticks = $urandom;
    else if (p < 3) clock_ticks -= $urandom_range(0, 500);
    else clock_ticks += $urandom_range(0, 400);
    c.now = clock_ticks;
    return c;
  endfunction

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) begin
      send_cmd(random_cmd());
      sent++;
      if (sent > RANDOM_ITEMS * 4 / 5) quiet = 1'b1;
    end
  endtask

  cmd_row_t directed_tbl [23] = '{
    // fresh grid reads back empty, inside and outside
    '{MODE_READ, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 32'd0, 1'b1, '{7'd0, 16'd0, 32'd0, 1'b1, 17'd0}},
    '{MODE_READ, 11'sd0, 11'sd0, -11'sd1024, 11'sd1023, 32'd0, 1'b1, '0},
    '{MODE_READ, 11'sd0, 11'sd0, 11'sd256, 11'sd0, 32'd0, 1'b1, '0},
    // corner cell reaches the detection count on the second hit
    '{MODE_MARK, 11'sd0, 11'sd0, 11'sd255, 11'sd255, 32'hFFFFFFFF, 1'b1,
      '{7'd0, 16'h0100, 32'hFFFFFFFF, 1'b1, 17'd0}},
    '{MODE_MARK, 11'sd0, 11'sd0, 11'sd255, 11'sd255, 32'hFFFFFFFF, 1'b1,
      '{7'd100, 16'h0200, 32'hFFFFFFFF, 1'b1, 17'd0}},
    '{MODE_MARK, 11'sd0, 11'sd0, 11'sd1023, -11'sd1024, 32'd5, 1'b1, '0},
    '{MODE_MARK, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 32'd10, 1'b0, '0},
    '{MODE_MARK, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 32'd20, 1'b0, '0},
    // zero-length ray clears nothing
    '{MODE_RAY, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 32'd0, 1'b0, '0},
    '{MODE_RAY, -11'sd5, -11'sd5, 11'sd3, 11'sd3, 32'd0, 1'b0, '0},
    '{MODE_RAY, 11'sd250, 11'sd250, 11'sd256, 11'sd256, 32'd0, 1'b0, '0},
    '{MODE_RAY, -11'sd1024, -11'sd1024, 11'sd1023, 11'sd1023, 32'd0, 1'b0, '0},
    '{MODE_MARK, 11'sd0, 11'sd0, 11'sd5, 11'sd5, 32'd100, 1'b0, '0},
    '{MODE_MARK, 11'sd0, 11'sd0, 11'sd5, 11'sd5, 32'd100, 1'b0, '0},
    '{MODE_MARK, 11'sd0, 11'sd0, 11'sd5, 11'sd5, 32'd100, 1'b0, '0},
    // time going backwards gives age zero
    '{MODE_SWEEP, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 32'd50, 1'b0, '0},
    '{MODE_SWEEP, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 32'd500, 1'b0, '0},
    '{MODE_READ, 11'sd0, 11'sd0, 11'sd5, 11'sd5, 32'd0, 1'b0, '0},
    '{MODE_SWEEP, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 32'd4000, 1'b0, '0},
    '{MODE_MARK, 11'sd0, 11'sd0, 11'sd0, 11'sd1, 32'd0, 1'b0, '0},
    '{MODE_MARK, 11'sd0, 11'sd0, 11'sd0, 11'sd1, 32'd0, 1'b0, '0},
    '{MODE_RAY, 11'sd0, 11'sd0, 11'sd0, 11'sd2, 32'd0, 1'b0, '0},
    '{MODE_READ, 11'sd0, 11'sd0, 11'sd0, 11'sd1, 32'd0, 1'b1,
      '{7'd0, 16'd0, 32'd0, 1'b1, 17'd0}}
  };

  initial begin
    cmd_row_t c;
    int unsigned dt;
    for (int i = 0; i < GW*GH; i++) begin
      occ_map[i] = 0; conf_map[i] = '0; seen_map[i] = '0;
    end
    min_det = MIN_DET_RST; decay_t = DECAY_TIME_RST; max_age_r = MAX_AGE_RST;
    sweep_en = 1'b1; cols = 256; rows = 256;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settle();

    foreach (directed_tbl[k]) send_cmd(directed_tbl[k]);
    settle();

    // one-cell grid, every hit occupies; hammer the cell past saturation
    load_regs(8'd0, 32'd0, 32'hFFFFFFFF, 1'b1, 9'd0, 9'd0);
    for (int k = 0; k < 260; k++) begin
      c = '0;
      c.mode = MODE_MARK;
      c.now = $urandom;
      send_cmd(c);
    end
    run_random(60);
    settle();

    // highest threshold, no ageing, wide and short grid
    load_regs(8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 9'd511, 9'd8);
    run_random(60);
    settle();

    // small grids with short decay windows
    for (int ph = 0; ph < 4; ph++) begin
      dt = $urandom_range(0, 200);
      load_regs(8'($urandom_range(1, 4)), dt, dt + $urandom_range(0, 400), 1'b1,
                9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)));
      run_random(62);
      settle();
    end

    repeat (40) @(negedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

>>> occupancy_grid_ray_update.f
sv/ogru_pkg.sv
sv/ogru_ram.sv
sv/occupancy_grid_ray_update.sv
sv/ogru_checker.sv
tb/occupancy_grid_ray_update_tb.sv
